@@ rtl/core/dtwsa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtwsa_pkg
// Shared widths, register codes, memory word layouts and the per-cell tag of
// the weighted-step DTW accumulator.
// ----------------------------------------------------------------------------
package dtwsa_pkg;

  localparam int COST_W       = 24;
  localparam int ACC_W        = 32;
  localparam int ROW_W        = 16;
  localparam int COL_IDX_W    = 10;
  localparam int CFG_COUNT_W  = 11;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int STEP_N       = 5;
  localparam int DEF_MAX_COLS = 1024;

  localparam logic [CFG_COUNT_W-1:0] RESET_COLUMN_COUNT = 11'd1024;
  localparam logic [ACC_W-1:0]       RESET_INFINITY     = 32'd4096000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COLUMN_COUNT   = 1'b0,
    CFG_INFINITY_VALUE = 1'b1
  } cfg_reg_t;

  // One column of the accumulated-cost store: rows i-1, i-2, i-3.
  typedef struct packed {
    logic [ACC_W-1:0] r1;
    logic [ACC_W-1:0] r2;
    logic [ACC_W-1:0] r3;
  } acc_word_t;

  // One column of the local-cost store: rows i-1, i-2.
  typedef struct packed {
    logic [COST_W-1:0] c1;
    logic [COST_W-1:0] c2;
  } cost_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row_index;
    logic [COL_IDX_W-1:0] col_index;
    logic                 row_end;
    logic                 row_ge1;
    logic                 row_ge2;
    logic                 row_ge3;
    logic                 col_ge1;
    logic                 col_ge2;
    logic                 col_ge3;
    logic                 origin;
  } cell_tag_t;

endpackage
`default_nettype wire

@@ rtl/core/dtwsa_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtwsa_if
// Valid/ready channels of the DTW accumulator: local cost in, result out.
// ----------------------------------------------------------------------------
interface dtwsa_cost_if;
  logic                        valid;
  logic                        ready;
  logic [dtwsa_pkg::COST_W-1:0] local_cost;
  logic                        first_cell;

  modport source (output valid, output local_cost, output first_cell, input ready);
  modport sink   (input valid, input local_cost, input first_cell, output ready);
endinterface

interface dtwsa_accum_if;
  logic                           valid;
  logic                           ready;
  logic [dtwsa_pkg::ACC_W-1:0]     accum_cost;
  logic [dtwsa_pkg::ROW_W-1:0]     row_index;
  logic [dtwsa_pkg::COL_IDX_W-1:0] col_index;
  logic                           row_end;

  modport source (output valid, output accum_cost, output row_index, output col_index,
                  output row_end, input ready);
  modport sink   (input valid, input accum_cost, input row_index, input col_index,
                  input row_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dtwsa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtwsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtwsa_ram #(
  parameter int WIDTH = dtwsa_pkg::ACC_W,
  parameter int DEPTH = dtwsa_pkg::DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dtwsa_sched.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtwsa_sched
// Configuration registers, row/column counters and input admission.
// ----------------------------------------------------------------------------
module dtwsa_sched #(
  parameter  int MAX_COLS = dtwsa_pkg::DEF_MAX_COLS,
  localparam int ColW     = $clog2(MAX_COLS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dtwsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dtwsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  input  logic                                first_cell,
  input  logic                                in_open,
  input  logic                                hazard,
  output logic                                in_ready,
  output logic                                accept,
  output logic [ColW-1:0]                     cell_col,
  output dtwsa_pkg::cell_tag_t                cell_tag,
  output logic [dtwsa_pkg::ACC_W-1:0]         infinity
);

  localparam int EffW = (ColW + 1 > dtwsa_pkg::CFG_COUNT_W) ? ColW + 1
                                                           : dtwsa_pkg::CFG_COUNT_W;
  localparam int JxW  = ColW + dtwsa_pkg::COL_IDX_W;

  logic [dtwsa_pkg::CFG_COUNT_W-1:0] column_count;
  logic [dtwsa_pkg::ROW_W-1:0]       row_counter;
  logic [ColW-1:0]                   col_counter;

  logic [dtwsa_pkg::ROW_W-1:0]       row_cur;
  logic [EffW-1:0]                   cc_ext;
  logic [EffW-1:0]                   eff;
  logic [EffW-1:0]                   col_plus;
  logic [JxW-1:0]                    col_wide;
  logic                              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= dtwsa_pkg::RESET_COLUMN_COUNT;
      infinity     <= dtwsa_pkg::RESET_INFINITY;
    end else if (cfg_write) begin
      unique case (dtwsa_pkg::cfg_reg_t'(cfg_index))
        dtwsa_pkg::CFG_COLUMN_COUNT:   column_count <= cfg_data[dtwsa_pkg::CFG_COUNT_W-1:0];
        dtwsa_pkg::CFG_INFINITY_VALUE: infinity     <= cfg_data[dtwsa_pkg::ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cc_ext   = EffW'(column_count);
    if (cc_ext == '0) begin
      eff = EffW'(1);
    end else if (cc_ext > EffW'(MAX_COLS)) begin
      eff = EffW'(MAX_COLS);
    end else begin
      eff = cc_ext;
    end
    cell_col = first_cell ? '0 : col_counter;
    row_cur  = first_cell ? '0 : row_counter;
    col_plus = EffW'(cell_col) + EffW'(1);
    last     = col_plus >= eff;
    col_wide = JxW'(cell_col);

    cell_tag.row_index = row_cur;
    cell_tag.col_index = col_wide[dtwsa_pkg::COL_IDX_W-1:0];
    cell_tag.row_end   = last;
    cell_tag.row_ge1   = row_cur != '0;
    cell_tag.row_ge2   = row_cur >= dtwsa_pkg::ROW_W'(2);
    cell_tag.row_ge3   = row_cur >= dtwsa_pkg::ROW_W'(3);
    cell_tag.col_ge1   = cell_col != '0;
    cell_tag.col_ge2   = cell_col >= ColW'(2);
    cell_tag.col_ge3   = cell_col >= ColW'(3);
    cell_tag.origin    = (row_cur == '0) && (cell_col == '0);

    in_ready = in_open && !hazard;
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
    end else if (accept) begin
      if (last) begin
        col_counter <= '0;
        if (row_cur != '1) begin
          row_counter <= row_cur + dtwsa_pkg::ROW_W'(1);
        end else begin
          row_counter <= row_cur;
        end
      end else begin
        col_counter <= col_plus[ColW-1:0];
        row_counter <= row_cur;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dtwsa_recur.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtwsa_recur
// Four-stage recursion pipeline with output register: step terms, saturating
// step sums, five-way minimum, write-back of the line stores.
// ----------------------------------------------------------------------------
module dtwsa_recur #(
  parameter  int MAX_COLS = dtwsa_pkg::DEF_MAX_COLS,
  localparam int ColW     = $clog2(MAX_COLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [ColW-1:0]               cell_col,
  input  dtwsa_pkg::cell_tag_t          cell_tag,
  input  logic [dtwsa_pkg::COST_W-1:0]  local_cost,
  input  logic [dtwsa_pkg::ACC_W-1:0]   infinity,
  output logic                          in_open,
  output logic                          hazard,
  input  dtwsa_pkg::acc_word_t          acc_rd,
  input  dtwsa_pkg::cost_word_t         cost_rd,
  output logic                          acc_wr_en,
  output logic [ColW-1:0]               acc_wr_addr,
  output dtwsa_pkg::acc_word_t          acc_wr_data,
  output logic                          cost_wr_en,
  output logic [ColW-1:0]               cost_wr_addr,
  output dtwsa_pkg::cost_word_t         cost_wr_data,
  dtwsa_accum_if.source                 res
);

  localparam int AW = dtwsa_pkg::ACC_W;
  localparam int KW = AW + 2;
  localparam int SW = KW + 1;
  localparam int N  = dtwsa_pkg::STEP_N;

  // stage 1
  logic                         s1_valid;
  dtwsa_pkg::cell_tag_t         s1_tag;
  logic [ColW-1:0]              s1_col;
  logic [dtwsa_pkg::COST_W-1:0] s1_cost;
  // row history along the current row
  dtwsa_pkg::acc_word_t         h1;
  logic [AW-1:0]                h2_r1;
  logic [AW-1:0]                h3_r1;
  logic [dtwsa_pkg::COST_W-1:0] recent0;
  logic [dtwsa_pkg::COST_W-1:0] recent1;
  // stage 2
  logic                         s2_valid;
  dtwsa_pkg::cell_tag_t         s2_tag;
  logic [ColW-1:0]              s2_col;
  logic [2*AW-1:0]              s2_keep;
  logic [AW-1:0]                s2_p [N];
  logic [KW-1:0]                s2_k [N];
  // stage 3
  logic                         s3_valid;
  dtwsa_pkg::cell_tag_t         s3_tag;
  logic [ColW-1:0]              s3_col;
  logic [2*AW-1:0]              s3_keep;
  logic [AW-1:0]                s3_t [N];
  // stage 4
  logic                         s4_valid;
  dtwsa_pkg::cell_tag_t         s4_tag;
  logic [ColW-1:0]              s4_col;
  logic [2*AW-1:0]              s4_keep;
  logic [AW-1:0]                s4_m0;
  logic [AW-1:0]                s4_m1;
  logic [AW-1:0]                s4_m2;

  logic out_en, s4_en, s3_en, s2_en;
  logic [AW-1:0] c_ext, c_i1, c_i2, c_j1, c_j2;
  logic [AW-1:0] p [N];
  logic [KW-1:0] k [N];
  logic [SW-1:0] sum [N];
  logic [AW-1:0] t [N];
  logic [AW-1:0] m01;
  logic [AW-1:0] d;

  // stage enables; an empty stage always takes
  always_comb begin
    out_en  = !res.valid || res.ready;
    s4_en   = out_en || !s4_valid;
    s3_en   = s4_en || !s3_valid;
    s2_en   = s3_en || !s2_valid;
    in_open = s2_en || !s1_valid;
    hazard  = (s1_valid && (s1_col == cell_col)) || (s2_valid && (s2_col == cell_col)) ||
              (s3_valid && (s3_col == cell_col)) || (s4_valid && (s4_col == cell_col));
  end

  // step terms
  always_comb begin
    c_ext = AW'(s1_cost);
    c_i1  = s1_tag.row_ge1 ? AW'(cost_rd.c1) : infinity;
    c_i2  = s1_tag.row_ge2 ? AW'(cost_rd.c2) : infinity;
    c_j1  = s1_tag.col_ge1 ? AW'(recent0) : infinity;
    c_j2  = s1_tag.col_ge2 ? AW'(recent1) : infinity;

    if (s1_tag.origin) begin
      p[0] = '0;
    end else begin
      p[0] = (s1_tag.row_ge1 && s1_tag.col_ge1) ? h1.r1 : infinity;
    end
    p[1] = (s1_tag.row_ge2 && s1_tag.col_ge1) ? h1.r2 : infinity;
    p[2] = (s1_tag.row_ge1 && s1_tag.col_ge2) ? h2_r1 : infinity;
    p[3] = (s1_tag.row_ge3 && s1_tag.col_ge1) ? h1.r3 : infinity;
    p[4] = (s1_tag.row_ge1 && s1_tag.col_ge3) ? h3_r1 : infinity;

    k[0] = KW'(c_ext);
    k[1] = KW'(c_i1) + KW'(c_ext);
    k[2] = KW'(c_j1) + KW'(c_ext);
    k[3] = KW'(c_i2) + KW'(c_i1) + KW'(c_ext);
    k[4] = KW'(c_j2) + KW'(c_j1) + KW'(c_ext);

    cost_wr_en        = s1_valid && s2_en;
    cost_wr_addr      = s1_col;
    cost_wr_data.c1   = s1_cost;
    cost_wr_data.c2   = cost_rd.c1;
  end

  // saturating step sums
  always_comb begin
    for (int n = 0; n < N; n++) begin
      sum[n] = SW'(s2_p[n]) + SW'(s2_k[n]);
      t[n]   = (sum[n][SW-1:AW] != '0) ? '1 : sum[n][AW-1:0];
    end
  end

  // final minimum and write-back
  always_comb begin
    m01                = (s4_m1 < s4_m0) ? s4_m1 : s4_m0;
    d                  = (s4_m2 < m01) ? s4_m2 : m01;
    acc_wr_en          = s4_valid && out_en;
    acc_wr_addr        = s4_col;
    acc_wr_data.r1     = d;
    acc_wr_data.r2     = s4_keep[2*AW-1:AW];
    acc_wr_data.r3     = s4_keep[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (in_open) begin
        s1_valid <= accept;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (s3_en) begin
        s3_valid <= s2_valid;
      end
      if (s4_en) begin
        s4_valid <= s3_valid;
      end
      if (out_en) begin
        res.valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag  <= cell_tag;
      s1_col  <= cell_col;
      s1_cost <= local_cost;
    end
    if (s1_valid && s2_en) begin
      h1      <= acc_rd;
      h2_r1   <= h1.r1;
      h3_r1   <= h2_r1;
      recent0 <= s1_cost;
      recent1 <= recent0;
    end
    if (s2_en) begin
      s2_tag  <= s1_tag;
      s2_col  <= s1_col;
      s2_keep <= {acc_rd.r1, acc_rd.r2};
      for (int n = 0; n < N; n++) begin
        s2_p[n] <= p[n];
        s2_k[n] <= k[n];
      end
    end
    if (s3_en) begin
      s3_tag  <= s2_tag;
      s3_col  <= s2_col;
      s3_keep <= s2_keep;
      for (int n = 0; n < N; n++) begin
        s3_t[n] <= t[n];
      end
    end
    if (s4_en) begin
      s4_tag  <= s3_tag;
      s4_col  <= s3_col;
      s4_keep <= s3_keep;
      s4_m0   <= (s3_t[1] < s3_t[0]) ? s3_t[1] : s3_t[0];
      s4_m1   <= (s3_t[3] < s3_t[2]) ? s3_t[3] : s3_t[2];
      s4_m2   <= s3_t[4];
    end
    if (out_en) begin
      res.accum_cost <= d;
      res.row_index  <= s4_tag.row_index;
      res.col_index  <= s4_tag.col_index;
      res.row_end    <= s4_tag.row_end;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dtw_weighted_step_accumulate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtw_weighted_step_accumulate
// Streaming DTW accumulator with steps (1,1) (2,1) (1,2) (3,1) (1,3),
// saturating Q20.12 costs, line stores kept in two column-indexed RAMs.
// ----------------------------------------------------------------------------
//  channel     dir  handshake        beat
//  cost_in     in   valid/ready      local_cost, first_cell
//  accum_out   out  valid/ready      accum_cost, row_index, col_index, row_end
//  cfg_*       in   cfg_write        cfg_index, cfg_data
//
//  One cell per cycle when rows hold five or more columns and results are
//  taken; in narrower rows a cell waits for the cell above it to leave stage
//  four (read-modify-write of the same RAM column).
//  Beats pass stages one to four and the output register; RAM read on accept.
//  Reset clears counters and valids and presets cfg; RAMs are not cleared.
//  A held result stalls only full stages; empty stages keep taking beats.
// ----------------------------------------------------------------------------
module dtw_weighted_step_accumulate #(
  parameter int MAX_COLS = dtwsa_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dtwsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dtwsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  dtwsa_cost_if.sink                        cost_in,
  dtwsa_accum_if.source                     accum_out
);

  localparam int ColW = $clog2(MAX_COLS);

  logic                        in_open;
  logic                        hazard;
  logic                        accept;
  logic [ColW-1:0]             cell_col;
  dtwsa_pkg::cell_tag_t        cell_tag;
  logic [dtwsa_pkg::ACC_W-1:0] infinity;

  dtwsa_pkg::acc_word_t  acc_rd;
  dtwsa_pkg::acc_word_t  acc_wr_data;
  logic                  acc_wr_en;
  logic [ColW-1:0]       acc_wr_addr;
  dtwsa_pkg::cost_word_t cost_rd;
  dtwsa_pkg::cost_word_t cost_wr_data;
  logic                  cost_wr_en;
  logic [ColW-1:0]       cost_wr_addr;

  dtwsa_sched #(.MAX_COLS(MAX_COLS)) u_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (cost_in.valid),
    .first_cell (cost_in.first_cell),
    .in_open    (in_open),
    .hazard     (hazard),
    .in_ready   (cost_in.ready),
    .accept     (accept),
    .cell_col   (cell_col),
    .cell_tag   (cell_tag),
    .infinity   (infinity)
  );

  dtwsa_ram #(.WIDTH($bits(dtwsa_pkg::acc_word_t)), .DEPTH(MAX_COLS)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_addr),
    .wr_data (acc_wr_data),
    .rd_en   (accept),
    .rd_addr (cell_col),
    .rd_data (acc_rd)
  );

  dtwsa_ram #(.WIDTH($bits(dtwsa_pkg::cost_word_t)), .DEPTH(MAX_COLS)) u_cost_ram (
    .clk     (clk),
    .wr_en   (cost_wr_en),
    .wr_addr (cost_wr_addr),
    .wr_data (cost_wr_data),
    .rd_en   (accept),
    .rd_addr (cell_col),
    .rd_data (cost_rd)
  );

  dtwsa_recur #(.MAX_COLS(MAX_COLS)) u_recur (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cell_col     (cell_col),
    .cell_tag     (cell_tag),
    .local_cost   (cost_in.local_cost),
    .infinity     (infinity),
    .in_open      (in_open),
    .hazard       (hazard),
    .acc_rd       (acc_rd),
    .cost_rd      (cost_rd),
    .acc_wr_en    (acc_wr_en),
    .acc_wr_addr  (acc_wr_addr),
    .acc_wr_data  (acc_wr_data),
    .cost_wr_en   (cost_wr_en),
    .cost_wr_addr (cost_wr_addr),
    .cost_wr_data (cost_wr_data),
    .res          (accum_out)
  );

endmodule
`default_nettype wire

@@ rtl/core/dtwsa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtwsa_checker
// Port-level checks of the DTW accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module dtwsa_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dtwsa_pkg::ACC_W-1:0]       accum_cost,
  input logic [dtwsa_pkg::ROW_W-1:0]       row_index,
  input logic [dtwsa_pkg::COL_IDX_W-1:0]   col_index,
  input logic                              row_end
);

  localparam logic [2:0] MaxInFlight = 3'd5;

  logic [2:0]                       pending;
  logic                             have_prev;
  logic [dtwsa_pkg::COL_IDX_W-1:0]  prev_col;
  logic                             prev_end;
  logic                             in_beat;
  logic                             out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      have_prev <= 1'b0;
    end else begin
      pending <= pending + {2'b0, in_beat} - {2'b0, out_beat};
      if (out_beat) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_col <= col_index;
      prev_end <= row_end;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(accum_cost) && $stable(row_index) &&
                                $stable(col_index) && $stable(row_end))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without an accepted beat");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= MaxInFlight)
    else $error("more beats in flight than pipeline stages");

  a_col_order: assert property (@(posedge clk) disable iff (rst)
    out_beat && have_prev |->
      (prev_end && col_index == '0) ||
      (!prev_end && (col_index == prev_col + 1'b1 || col_index == '0)))
    else $error("column order broken");

endmodule

bind dtw_weighted_step_accumulate dtwsa_checker u_dtwsa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cost_in.valid),
  .in_ready   (cost_in.ready),
  .out_valid  (accum_out.valid),
  .out_ready  (accum_out.ready),
  .accum_cost (accum_out.accum_cost),
  .row_index  (accum_out.row_index),
  .col_index  (accum_out.col_index),
  .row_end    (accum_out.row_end)
);
`default_nettype wire

@@ test/dtw_weighted_step_accumulate_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtw_weighted_step_accumulate_test
// Streams local costs through the weighted-step DTW accumulator and checks
// every accumulated cost, row and column index and row end against table
// values or a cell-by-cell five-step recursion model. The run has four parts:
// - a short table of hand-picked cells and register writes;
// - random matrices of mostly narrow widths, with random infinity values and
//   occasional restarts in the middle of a matrix;
// - just over one row at full width;
// - a one-column matrix that runs the row index into saturation.
// Both channels idle at random, except for one stretch with no idling.
// ----------------------------------------------------------------------------
module dtw_weighted_step_accumulate_test;
  import dtwsa_pkg::*;

  localparam int MAX_COLS      = DEF_MAX_COLS;
  localparam int IDLE_PCT      = 29;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_CELLS  = 1150;
  localparam int ROW_SAT_CELLS = 65542;
  localparam int PLAN_ROWS     = 30;

  typedef struct packed {
    logic [ACC_W-1:0]     accum_cost;
    logic [ROW_W-1:0]     row_index;
    logic [COL_IDX_W-1:0] col_index;
    logic                 row_end;
  } cell_result_t;

  typedef enum logic {STEP_CELL, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic [COST_W-1:0]     cost;
    logic                  start;
    logic                  known;
    cell_result_t          want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dtwsa_cost_if  cost_ch ();
  dtwsa_accum_if accum_ch ();

  dtw_weighted_step_accumulate #(
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cost_in   (cost_ch.sink),
    .accum_out (accum_ch.source)
  );

  always #6 clk = ~clk;

  // Model state: accumulated rows i-1..i-3, local-cost rows i-1..i-2.
  logic [ACC_W-1:0]       acc_rows [3*MAX_COLS];
  logic [COST_W-1:0]      cost_rows [2*MAX_COLS];
  logic [COST_W-1:0]      left_cost [2] = '{'0, '0};
  logic [ROW_W-1:0]       row_pos = '0;
  int unsigned            col_pos = 0;
  int unsigned            acc_slot = 0;
  int unsigned            cost_slot = 0;
  logic [ACC_W-1:0]       held_acc = '0;
  logic [CFG_COUNT_W-1:0] width_reg = RESET_COLUMN_COUNT;
  logic [ACC_W-1:0]       inf_reg = RESET_INFINITY;

  cell_result_t due_cells [$];
  cell_result_t due_head;
  int           cells_sent = 0;
  int           cells_returned = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           steady = 1'b0;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'hFF_FFFF, 1'b0, 1'b1,
      '{32'h00FF_FFFF, 16'd0, 10'd0, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0000, 1'b0, 1'b1,
      '{32'h003E_8000, 16'd0, 10'd1, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0001, 1'b1, 1'b1,
      '{32'h0000_0001, 16'd0, 10'd0, 1'b0}},
    '{STEP_WRITE, CFG_COLUMN_COUNT,   32'hFFFF_F803, 24'h0, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'hAB_CDEF, 1'b1, 1'b1,
      '{32'h00AB_CDEF, 16'd0, 10'd0, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0005, 1'b0, 1'b1,
      '{32'h003E_8005, 16'd0, 10'd1, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h12_3456, 1'b0, 1'b1,
      '{32'h0050_B456, 16'd0, 10'd2, 1'b1}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0100, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0200, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'hFF_FFFF, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0003, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0000, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0777, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0010, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0020, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0030, 1'b0, 1'b0, '0},
    '{STEP_WRITE, CFG_INFINITY_VALUE, 32'hFFFF_FFFF, 24'h0, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0010, 1'b1, 1'b1,
      '{32'h0000_0010, 16'd0, 10'd0, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0001, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 16'd0, 10'd1, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'hFF_FFFF, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 16'd0, 10'd2, 1'b1}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0002, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0003, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0004, 1'b0, 1'b0, '0},
    '{STEP_WRITE, CFG_INFINITY_VALUE, 32'h0000_0000, 24'h0, 1'b0, 1'b0, '0},
    '{STEP_WRITE, CFG_COLUMN_COUNT,   32'h0000_0000, 24'h0, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0007, 1'b1, 1'b1,
      '{32'h0000_0007, 16'd0, 10'd0, 1'b1}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0009, 1'b0, 1'b1,
      '{32'h0000_0009, 16'd1, 10'd0, 1'b1}},
    '{STEP_WRITE, CFG_COLUMN_COUNT,   32'h0000_07FF, 24'h0, 1'b0, 1'b0, '0},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'hFF_FFFF, 1'b1, 1'b1,
      '{32'h00FF_FFFF, 16'd0, 10'd0, 1'b0}},
    '{STEP_CELL,  CFG_COLUMN_COUNT,   32'h0, 24'h00_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 16'd0, 10'd1, 1'b0}}
  };

  function automatic longint unsigned sat_sum(input longint unsigned a,
                                              input longint unsigned b);
    return (a + b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a + b;
  endfunction

  function automatic cell_result_t accumulate_cell(input logic [COST_W-1:0] cost,
                                                   input logic start);
    longint unsigned inf, c, up1, up2, left1, left2, best;
    longint unsigned p11, p21, p12, p31, p13;
    longint unsigned step_cost [STEP_N];
    int unsigned     eff, i, j, s1, s2, s3, here;
    cell_result_t    res;
    inf = inf_reg;
    c = cost;
    eff = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
    if (start) begin
      row_pos = '0;
      col_pos = 0;
      acc_slot = 0;
      cost_slot = 0;
    end
    i = row_pos;
    j = col_pos;
    s1 = acc_slot;
    s2 = (acc_slot + 1) % 3;
    s3 = (acc_slot + 2) % 3;
    here = cost_slot ^ 1;
    up1 = (i >= 1) ? cost_rows[cost_slot * MAX_COLS + j] : inf;
    up2 = (i >= 2) ? cost_rows[here * MAX_COLS + j] : inf;
    left1 = (j >= 1) ? left_cost[0] : inf;
    left2 = (j >= 2) ? left_cost[1] : inf;
    if (i == 0 && j == 0) begin
      best = c;
    end else begin
      p11 = (i >= 1 && j >= 1) ? acc_rows[s1 * MAX_COLS + j - 1] : inf;
      p21 = (i >= 2 && j >= 1) ? acc_rows[s2 * MAX_COLS + j - 1] : inf;
      p12 = (i >= 1 && j >= 2) ? acc_rows[s1 * MAX_COLS + j - 2] : inf;
      p31 = (i >= 3 && j >= 1) ? acc_rows[s3 * MAX_COLS + j - 1] : inf;
      p13 = (i >= 1 && j >= 3) ? acc_rows[s1 * MAX_COLS + j - 3] : inf;
      step_cost[0] = sat_sum(p11, c);
      step_cost[1] = sat_sum(sat_sum(p21, up1), c);
      step_cost[2] = sat_sum(sat_sum(p12, left1), c);
      step_cost[3] = sat_sum(sat_sum(sat_sum(p31, up2), up1), c);
      step_cost[4] = sat_sum(sat_sum(sat_sum(p13, left2), left1), c);
      best = step_cost[0];
      foreach (step_cost[k]) begin
        if (step_cost[k] < best) best = step_cost[k];
      end
    end
    // write the previous cell back one cell late, into the slot of row i-3
    if (j >= 1) acc_rows[s3 * MAX_COLS + j - 1] = held_acc;
    held_acc = best[ACC_W-1:0];
    cost_rows[here * MAX_COLS + j] = cost;
    left_cost[1] = left_cost[0];
    left_cost[0] = cost;
    res.accum_cost = best[ACC_W-1:0];
    res.row_index = row_pos;
    res.col_index = j[COL_IDX_W-1:0];
    res.row_end = (j + 1 >= eff);
    if (res.row_end) begin
      acc_rows[s3 * MAX_COLS + j] = best[ACC_W-1:0];
      col_pos = 0;
      if (row_pos != '1) row_pos = row_pos + 1'b1;
      acc_slot = s3;
      cost_slot = here;
    end else begin
      col_pos = j + 1;
    end
    return res;
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 55) return $urandom_range(0, 4095);
    return $urandom();
  endfunction

  function automatic logic [ACC_W-1:0] pick_infinity();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return RESET_INFINITY;
    if (pick < 40) return '1;
    if (pick < 50) return '0;
    if (pick < 75) return $urandom();
    return $urandom_range(0, 32'h00FF_FFFF);
  endfunction

  task automatic send_cell(input logic [COST_W-1:0] cost, input logic start,
                           input logic known, input cell_result_t typed);
    cell_result_t predicted;
    cfg_write <= 1'b0;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cost_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cost_ch.valid      <= 1'b1;
    cost_ch.local_cost <= cost;
    cost_ch.first_cell <= start;
    do @(posedge clk); while (!cost_ch.ready);
    predicted = accumulate_cell(cost, start);
    due_cells.push_back(known ? typed : predicted);
    cells_sent++;
  endtask

  // Write only once every result has come back; leave the write enable for the
  // next beat or write to settle.
  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    cost_ch.valid <= 1'b0;
    while (cells_returned != cells_sent) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    if (sel == CFG_COLUMN_COUNT) width_reg = value[CFG_COUNT_W-1:0];
    else inf_reg = value;
  endtask

  task automatic flag_mismatch(input string field, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      accum_ch.ready <= 1'b0;
    end else begin
      accum_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && accum_ch.valid && accum_ch.ready) begin
      cells_returned <= cells_returned + 1;
      if (due_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t ns: accum_cost expected none, got %0h", $time, accum_ch.accum_cost);
      end else begin
        due_head = due_cells.pop_front();
        if (accum_ch.accum_cost !== due_head.accum_cost)
          flag_mismatch("accum_cost", due_head.accum_cost, accum_ch.accum_cost);
        if (accum_ch.row_index !== due_head.row_index)
          flag_mismatch("row_index", due_head.row_index, accum_ch.row_index);
        if (accum_ch.col_index !== due_head.col_index)
          flag_mismatch("col_index", due_head.col_index, accum_ch.col_index);
        if (accum_ch.row_end !== due_head.row_end)
          flag_mismatch("row_end", due_head.row_end, accum_ch.row_end);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cost_ch.valid && cost_ch.ready) || (accum_ch.valid && accum_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned           pick, eff_w, rows, cells, random_cells;
    logic [CFG_DATA_W-1:0] width_data;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_COLUMN_COUNT;
    cfg_data = '0;
    cost_ch.valid = 1'b0;
    cost_ch.local_cost = '0;
    cost_ch.first_cell = 1'b0;
    accum_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[n]) begin
      if (directed_plan[n].kind == STEP_WRITE) begin
        write_register(directed_plan[n].reg_sel, directed_plan[n].value);
      end else begin
        send_cell(directed_plan[n].cost, directed_plan[n].start, directed_plan[n].known,
                  directed_plan[n].want);
      end
    end

    // random matrices, each opening with a restart after new settings
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) width_data = $urandom_range(1, 5);
      else if (pick < 75) width_data = $urandom_range(6, 16);
      else if (pick < 92) width_data = $urandom_range(17, 64);
      else if (pick < 96) width_data = '0;
      else width_data = $urandom_range(65, 100);
      eff_w = (width_data == 0) ? 1 : width_data;
      rows = (eff_w > 64) ? $urandom_range(4, 5) : $urandom_range(4, 12);
      cells = rows * eff_w + $urandom_range(0, eff_w - 1);
      steady = (random_cells >= 300 && random_cells < 650);
      write_register(CFG_COLUMN_COUNT, ($urandom() & ~32'h7FF) | width_data);
      write_register(CFG_INFINITY_VALUE, pick_infinity());
      for (int n = 0; n < cells; n++) begin
        send_cell(pick_cost(), n == 0 || $urandom_range(0, 199) == 0, 1'b0, '0);
      end
      random_cells += cells;
    end
    steady = 1'b0;

    // full-width rows: register above the maximum, clamped
    write_register(CFG_COLUMN_COUNT, ($urandom() & ~32'h7FF) | $urandom_range(1025, 2046));
    write_register(CFG_INFINITY_VALUE, pick_infinity());
    cells = MAX_COLS + $urandom_range(8, 64);
    for (int n = 0; n < cells; n++) begin
      send_cell(pick_cost(), n == 0, 1'b0, '0);
    end

    // one column: drive the row index into saturation
    write_register(CFG_COLUMN_COUNT, ($urandom() & ~32'h7FF) | 32'd1);
    write_register(CFG_INFINITY_VALUE, pick_infinity());
    for (int n = 0; n < ROW_SAT_CELLS; n++) begin
      send_cell(pick_cost(), n == 0, 1'b0, '0);
    end

    cost_ch.valid <= 1'b0;
    cfg_write <= 1'b0;
    while (cells_returned != cells_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_cells.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dtwsa_pkg.sv
rtl/core/dtwsa_if.sv
rtl/core/dtwsa_ram.sv
rtl/core/dtwsa_sched.sv
rtl/core/dtwsa_recur.sv
rtl/core/dtw_weighted_step_accumulate.sv
rtl/core/dtwsa_checker.sv
test/dtw_weighted_step_accumulate_test.sv
